// ===== rtl/mslru_pkg.sv =====
// Shared types and constants of the midpoint split LRU replacer.
package mslru_pkg;

    localparam int FRAME_W = 6;
    localparam int POS_W   = 10;
    localparam int CNT_W   = 11;

    localparam logic [1:0] CMD_VICTIM = 2'd0;
    localparam logic [1:0] CMD_PIN    = 2'd1;
    localparam logic [1:0] CMD_UNPIN  = 2'd2;

    typedef struct packed {
        logic [FRAME_W-1:0] frame;
        logic               ev_shift;
        logic [POS_W-1:0]   ev_pos;
        logic               ev_load;
        logic [FRAME_W-1:0] ev_load_val;
        logic [CNT_W-1:0]   ev_count;
        logic               en_shift;
        logic [POS_W-1:0]   en_pos;
        logic               en_ins;
        logic [CNT_W-1:0]   en_count;
    } mslru_ctrl_t;

endpackage

// ===== rtl/mslru_cell.sv =====
// One cell of the list chain: holds one eviction slot and one entry slot.
module mslru_cell
    import mslru_pkg::*;
#(
    parameter int IDX = 0
)
(
    input  logic               clk,
    input  mslru_ctrl_t        ctrl,
    input  logic [FRAME_W-1:0] ev_from_left,
    input  logic [FRAME_W-1:0] en_from_left,
    input  logic [FRAME_W-1:0] en_from_right,
    output logic [FRAME_W-1:0] ev_val,
    output logic [FRAME_W-1:0] en_val,
    output logic               ev_match,
    output logic               en_match
);

    localparam logic [CNT_W-1:0] MY = CNT_W'(IDX);

    logic [FRAME_W-1:0] ev_reg;
    logic [FRAME_W-1:0] ev_next;
    logic [FRAME_W-1:0] en_reg;
    logic [FRAME_W-1:0] en_next;

    always_comb
    begin
        ev_next = ev_reg;
        if (ctrl.ev_shift && (MY >= CNT_W'(ctrl.ev_pos)))
        begin
            ev_next = ev_from_left;
        end
        else if (ctrl.ev_load && (MY == ctrl.ev_count))
        begin
            ev_next = ctrl.ev_load_val;
        end
        en_next = en_reg;
        if (ctrl.en_shift && (MY >= CNT_W'(ctrl.en_pos)))
        begin
            en_next = en_from_left;
        end
        else if (ctrl.en_ins)
        begin
            en_next = en_from_right;
        end
    end

    always_ff @(posedge clk)
    begin
        ev_reg <= ev_next;
        en_reg <= en_next;
    end

    assign ev_val   = ev_reg;
    assign en_val   = en_reg;
    assign ev_match = (MY < ctrl.ev_count) && (ev_reg == ctrl.frame);
    assign en_match = (MY < ctrl.en_count) && (en_reg == ctrl.frame);

endmodule

// ===== rtl/mslru_enc.sv =====
// Position encoder over the one-hot match bits of a list.
module mslru_enc
    import mslru_pkg::*;
#(
    parameter int N = 64
)
(
    input  logic [N-1:0]     match,
    output logic             hit,
    output logic [POS_W-1:0] pos
);

    always_comb
    begin
        pos = '0;
        for (int i = 0; i < N; i++)
        begin
            if (match[i])
            begin
                pos = pos | POS_W'(i);
            end
        end
    end

    assign hit = |match;

endmodule

// ===== rtl/midpoint_split_lru_replacer.sv =====
// Top level of the midpoint split LRU replacer: sequencer, cell chain, registers.
//
// Usage: a command (cmd, frame) is taken at a rising edge where start is high
// and busy is low. cmd victim pops the eviction list head, pin drops a frame
// from whichever list holds it, unpin pushes an untracked frame at the head
// of the entry list when fewer than capacity frames are tracked.
// Exactly one result per command appears on victim_found, victim_frame and
// tracked_count for one cycle, marked by done; it cannot be held off.
// Sequence: accept, a parallel match across the cell chain (S_LOOK), the
// shift applied (S_EXEC), then the result cycle (S_OUT) in which done is high.
// A command that rebalances spends a check plus one S_BAL step per frame
// moved from entry list to eviction list before the result cycle. busy drops
// in the cycle after done, and a new command can then be taken.
// Each cell moves its slots to a neighbour in a registered shift; the rebalance
// loop moves one frame per cycle. Config writes over the APB port (capacity
// at 0x0, split_ratio at 0x4) are taken whenever; issue them while idle.
// Reset empties both lists (counts to zero), capacity 64, split_ratio 1.
module midpoint_split_lru_replacer
    import mslru_pkg::*;
#(
    parameter int NUM_FRAMES = 64
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    output logic               busy,
    input  logic [1:0]         cmd,
    input  logic [FRAME_W-1:0] frame,
    output logic               done,
    output logic               victim_found,
    output logic [FRAME_W-1:0] victim_frame,
    output logic [6:0]         tracked_count,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [2:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready
);

    localparam int CW = $clog2(NUM_FRAMES + 1);
    localparam int PW = CW + 4;

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_LOOK = 3'd1;
    localparam logic [2:0] S_EXEC = 3'd2;
    localparam logic [2:0] S_BAL  = 3'd3;
    localparam logic [2:0] S_OUT  = 3'd4;

    logic [2:0]         state_reg, state_next;
    logic [1:0]         cmd_reg;
    logic [FRAME_W-1:0] frame_reg;
    logic [CW-1:0]      ev_cnt_reg, ev_cnt_next;
    logic [CW-1:0]      en_cnt_reg, en_cnt_next;
    logic [6:0]         cap_reg;
    logic [3:0]         ratio_reg;
    logic               found_reg, found_next;
    logic [FRAME_W-1:0] vframe_reg, vframe_next;
    logic               ev_hit_reg, en_hit_reg;
    logic [POS_W-1:0]   ev_pos_reg, en_pos_reg;

    mslru_ctrl_t        ctrl;
    logic [FRAME_W-1:0] ev_q [NUM_FRAMES];
    logic [FRAME_W-1:0] en_q [NUM_FRAMES];
    logic [NUM_FRAMES-1:0] ev_m, en_m;
    logic               ev_hit, en_hit;
    logic [POS_W-1:0]   ev_pos, en_pos;
    logic               frame_ok;
    logic [CW:0]        total;
    logic               need_move;
    logic               cfg_wr;

    // Cell chain: slot i takes slot i+1 on a left shift, slot i-1 on insert.
    for (genvar i = 0; i < NUM_FRAMES; i++)
    begin : g_cell
        logic [FRAME_W-1:0] ev_left, en_left, en_right;
        if (i + 1 < NUM_FRAMES)
        begin : g_l
            assign ev_left = ev_q[i+1];
            assign en_left = en_q[i+1];
        end
        else
        begin : g_e
            assign ev_left = ev_q[i];
            assign en_left = en_q[i];
        end
        if (i == 0)
        begin : g_h
            assign en_right = frame_reg;
        end
        else
        begin : g_r
            assign en_right = en_q[i-1];
        end
        mslru_cell #(.IDX(i)) u_cell
        (
            .clk           (clk),
            .ctrl          (ctrl),
            .ev_from_left  (ev_left),
            .en_from_left  (en_left),
            .en_from_right (en_right),
            .ev_val        (ev_q[i]),
            .en_val        (en_q[i]),
            .ev_match      (ev_m[i]),
            .en_match      (en_m[i])
        );
    end

    mslru_enc #(.N(NUM_FRAMES)) u_ev_enc (.match(ev_m), .hit(ev_hit), .pos(ev_pos));
    mslru_enc #(.N(NUM_FRAMES)) u_en_enc (.match(en_m), .hit(en_hit), .pos(en_pos));

    assign frame_ok  = (32'(frame_reg) < 32'(NUM_FRAMES));
    assign total     = (CW+1)'(ev_cnt_reg) + (CW+1)'(en_cnt_reg);
    // Move while the eviction list is short of entry_count / split_ratio.
    assign need_move = (en_cnt_reg != '0) && (32'(ev_cnt_reg) < 32'(NUM_FRAMES)) &&
                       ((PW'(ev_cnt_reg) * PW'(ratio_reg)) < PW'(en_cnt_reg));

    always_comb
    begin
        state_next  = state_reg;
        ev_cnt_next = ev_cnt_reg;
        en_cnt_next = en_cnt_reg;
        found_next  = found_reg;
        vframe_next = vframe_reg;
        ctrl             = '0;
        ctrl.frame       = frame_reg;
        ctrl.ev_count    = CNT_W'(ev_cnt_reg);
        ctrl.en_count    = CNT_W'(en_cnt_reg);
        ctrl.ev_load_val = en_q[0];
        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    state_next = S_LOOK;
                end
            end
            S_LOOK:
            begin
                found_next  = 1'b0;
                vframe_next = '0;
                state_next  = S_EXEC;
            end
            S_EXEC:
            begin
                state_next = S_OUT;
                case (cmd_reg)
                    CMD_VICTIM:
                    begin
                        if (ev_cnt_reg != '0)
                        begin
                            found_next    = 1'b1;
                            vframe_next   = ev_q[0];
                            ctrl.ev_shift = 1'b1;
                            ctrl.ev_pos   = '0;
                            ev_cnt_next   = ev_cnt_reg - 1'b1;
                            state_next    = S_BAL;
                        end
                    end
                    CMD_PIN:
                    begin
                        if (frame_ok && ev_hit_reg)
                        begin
                            ctrl.ev_shift = 1'b1;
                            ctrl.ev_pos   = ev_pos_reg;
                            ev_cnt_next   = ev_cnt_reg - 1'b1;
                            state_next    = S_BAL;
                        end
                        else if (frame_ok && en_hit_reg)
                        begin
                            ctrl.en_shift = 1'b1;
                            ctrl.en_pos   = en_pos_reg;
                            en_cnt_next   = en_cnt_reg - 1'b1;
                        end
                    end
                    CMD_UNPIN:
                    begin
                        if (frame_ok && (32'(total) < 32'(cap_reg)) && !ev_hit_reg &&
                            !en_hit_reg && (32'(en_cnt_reg) < 32'(NUM_FRAMES)))
                        begin
                            ctrl.en_ins = 1'b1;
                            en_cnt_next = en_cnt_reg + 1'b1;
                            state_next  = S_BAL;
                        end
                    end
                    default:
                    begin
                        state_next = S_OUT;
                    end
                endcase
            end
            S_BAL:
            begin
                if (need_move)
                begin
                    // Append entry head at eviction tail, drop it from entry list.
                    ctrl.ev_load  = 1'b1;
                    ctrl.en_shift = 1'b1;
                    ctrl.en_pos   = '0;
                    ev_cnt_next   = ev_cnt_reg + 1'b1;
                    en_cnt_next   = en_cnt_reg - 1'b1;
                end
                else
                begin
                    state_next = S_OUT;
                end
            end
            S_OUT:
            begin
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            ev_cnt_reg <= '0;
            en_cnt_reg <= '0;
            cap_reg    <= 7'd64;
            ratio_reg  <= 4'd1;
        end
        else
        begin
            state_reg  <= state_next;
            ev_cnt_reg <= ev_cnt_next;
            en_cnt_reg <= en_cnt_next;
            if (cfg_wr && !paddr[2])
            begin
                cap_reg <= pwdata[6:0];
            end
            if (cfg_wr && paddr[2])
            begin
                ratio_reg <= pwdata[3:0];
            end
        end
    end

    // Payload: hold the command, latch the match results.
    always_ff @(posedge clk)
    begin
        if (state_reg == S_IDLE && start)
        begin
            cmd_reg   <= cmd;
            frame_reg <= frame;
        end
        if (state_reg == S_LOOK)
        begin
            ev_hit_reg <= ev_hit;
            en_hit_reg <= en_hit;
            ev_pos_reg <= ev_pos;
            en_pos_reg <= en_pos;
        end
        found_reg  <= found_next;
        vframe_reg <= vframe_next;
    end

    assign cfg_wr = psel && penable && pwrite;
    assign pready = 1'b1;
    assign prdata = paddr[2] ? {28'd0, ratio_reg} : {25'd0, cap_reg};

    assign busy          = (state_reg != S_IDLE);
    assign done          = (state_reg == S_OUT);
    assign victim_found  = found_reg;
    assign victim_frame  = vframe_reg;
    assign tracked_count = 7'(total);

    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy)
        else $error("accepted command did not raise busy");
    a_done_single: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done && !busy)
        else $error("result strobe longer than one cycle");
    a_total_bound: assert property (@(posedge clk) disable iff (!rst_n)
        32'(total) <= 32'(NUM_FRAMES))
        else $error("tracked frames exceed frame count");
    a_found_frame: assert property (@(posedge clk) disable iff (!rst_n)
        (done && !victim_found) |-> (victim_frame == '0))
        else $error("victim frame set without victim");

endmodule
